@@ rtl/lte_pkg.sv @@
`timescale 1ns / 1ps
package lte_pkg;

  // Default number of tracked blocks.
  localparam int unsigned CAPACITY = 64;

  // Fixed field widths.
  localparam int unsigned TAG_W = 63;
  localparam int unsigned CNT_W = 7;

  // Reset value of the eviction threshold.
  localparam logic [CNT_W-1:0] THRESHOLD_RST = 7'd48;

  // Input operation codes.
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_TICK   = 1'b1;

endpackage

@@ rtl/lte_in_if.sv @@
`timescale 1ns / 1ps
interface lte_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [lte_pkg::TAG_W-1:0] block_number;

  modport source (output valid, output op, output block_number, input ready);
  modport sink   (input valid, input op, input block_number, output ready);
endinterface

@@ rtl/lte_out_if.sv @@
`timescale 1ns / 1ps
interface lte_out_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic                      evict_valid;
  logic [lte_pkg::TAG_W-1:0] evicted_block;
  logic [lte_pkg::CNT_W-1:0] resident_count;
  logic                      last;

  modport source (output valid, output hit, output evict_valid, output evicted_block,
                  output resident_count, output last, input ready);
  modport sink   (input valid, input hit, input evict_valid, input evicted_block,
                  input resident_count, input last, output ready);
endinterface

@@ rtl/lru_tracker_threshold_evict.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Beat contents
// in_i    | in  | op, block_number
// out_o   | out | hit, evict_valid, evicted_block, resident_count, last
// cfg     | in  | cfg_we_i / cfg_wdata_i write the eviction threshold
//
// An access walks the tag RAM one rank per cycle from the most recent entry
// while the entries ahead of the match are shifted down one rank over the same
// single write port.
// A tick evicts one block per pass through ST_TREAD and ST_TEVICT while the count
// exceeds the threshold; when nothing is evicted, no RAM read is made.
// Reset empties the set at once; no clearing pass is needed.
// A finished result waits in the output register while the next beat is taken.
module lru_tracker_threshold_evict #(
  parameter int unsigned CAPACITY = lte_pkg::CAPACITY
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lte_pkg::CNT_W-1:0] cfg_wdata_i,
  lte_in_if.sink                    in_i,
  lte_out_if.source                 out_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > lte_pkg::CNT_W) ? CW : lte_pkg::CNT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MFIN, ST_EMIT, ST_TREAD, ST_TEVICT
  } state_e;

  typedef logic [lte_pkg::TAG_W-1:0] tag_t;

  state_e                    state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             ra_q, ra_d;
  logic [AW-1:0]             rr_q, rr_d;
  tag_t                      prev_q, prev_d;
  tag_t                      blk_q, blk_d;
  logic [lte_pkg::CNT_W-1:0] thr_q;
  // Pending result.
  logic                      p_hit_q, p_hit_d, p_ev_q, p_ev_d;
  tag_t                      p_blk_q, p_blk_d;
  // Output register.
  logic                      o_vld_q, o_vld_d, o_hit_q, o_hit_d, o_ev_q, o_ev_d;
  logic                      o_last_q, o_last_d;
  tag_t                      o_blk_q, o_blk_d;
  logic [CW-1:0]             o_cnt_q, o_cnt_d;

  logic                      rd_en, wr_en;
  logic [AW-1:0]             rd_addr, wr_addr;
  tag_t                      rd_data, wr_data;
  logic                      out_free, match, scan_end;
  logic [CW-1:0]             cnt_m1;
  logic [CMPW-1:0]           cnt_x, cnt_m1_x, thr_x;

  lte_tag_ram #(.DEPTH(CAPACITY)) u_tag_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign out_free = !o_vld_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cnt_m1   = count_q - CW'(1);
  assign cnt_x    = CMPW'(count_q);
  assign cnt_m1_x = CMPW'(cnt_m1);
  assign thr_x    = CMPW'(thr_q);
  assign match    = (rd_data == blk_q);
  assign scan_end = (CW'(rr_q) == cnt_m1);

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= lte_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Sequencer: walk, shift and evict.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ra_d     = ra_q;
    rr_d     = rr_q;
    prev_d   = prev_q;
    blk_d    = blk_q;
    p_hit_d  = p_hit_q;
    p_ev_d   = p_ev_q;
    p_blk_d  = p_blk_q;
    o_vld_d  = o_vld_q && !out_o.ready;
    o_hit_d  = o_hit_q;
    o_ev_d   = o_ev_q;
    o_blk_d  = o_blk_q;
    o_cnt_d  = o_cnt_q;
    o_last_d = o_last_q;
    rd_en    = 1'b0;
    rd_addr  = ra_q[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = blk_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          blk_d = in_i.block_number;
          if (in_i.op == lte_pkg::OP_TICK) begin
            if (cnt_x > thr_x) begin
              state_d = ST_TREAD;
            end else begin
              p_hit_d = 1'b0;
              p_ev_d  = 1'b0;
              p_blk_d = '0;
              state_d = ST_EMIT;
            end
          end else if (count_q == '0) begin
            // Empty set: the block goes straight to rank 0.
            wr_en   = 1'b1;
            wr_data = in_i.block_number;
            count_d = CW'(1);
            p_hit_d = 1'b0;
            p_ev_d  = 1'b0;
            p_blk_d = '0;
            state_d = ST_EMIT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            rr_d    = '0;
            ra_d    = CW'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Each returned rank is shifted down one place as it is compared.
        wr_en   = 1'b1;
        wr_addr = rr_q;
        wr_data = (rr_q == '0) ? blk_q : prev_q;
        prev_d  = rd_data;
        if (match) begin
          p_hit_d = 1'b1;
          p_ev_d  = 1'b0;
          p_blk_d = '0;
          state_d = ST_EMIT;
        end else if (scan_end) begin
          if (count_q == CAP_C) begin
            // Full set: the oldest tag falls off the end.
            p_hit_d = 1'b0;
            p_ev_d  = 1'b1;
            p_blk_d = rd_data;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_MFIN;
          end
        end else begin
          rd_en = (ra_q < count_q);
          rr_d  = ra_q[AW-1:0];
          ra_d  = ra_q + CW'(1);
        end
      end
      ST_MFIN: begin
        // Miss with room: the former oldest tag moves to the new last rank.
        wr_en   = 1'b1;
        wr_addr = count_q[AW-1:0];
        wr_data = prev_q;
        count_d = count_q + CW'(1);
        p_hit_d = 1'b0;
        p_ev_d  = 1'b0;
        p_blk_d = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          o_vld_d  = 1'b1;
          o_hit_d  = p_hit_q;
          o_ev_d   = p_ev_q;
          o_blk_d  = p_blk_q;
          o_cnt_d  = count_q;
          o_last_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_TREAD: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[AW-1:0];
        state_d = ST_TEVICT;
      end
      ST_TEVICT: begin
        if (out_free) begin
          o_vld_d  = 1'b1;
          o_hit_d  = 1'b0;
          o_ev_d   = 1'b1;
          o_blk_d  = rd_data;
          o_cnt_d  = cnt_m1;
          o_last_d = (cnt_m1_x <= thr_x);
          count_d  = cnt_m1;
          state_d  = (cnt_m1_x <= thr_x) ? ST_IDLE : ST_TREAD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      o_vld_q <= o_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ra_q     <= ra_d;
    rr_q     <= rr_d;
    prev_q   <= prev_d;
    blk_q    <= blk_d;
    p_hit_q  <= p_hit_d;
    p_ev_q   <= p_ev_d;
    p_blk_q  <= p_blk_d;
    o_hit_q  <= o_hit_d;
    o_ev_q   <= o_ev_d;
    o_blk_q  <= o_blk_d;
    o_cnt_q  <= o_cnt_d;
    o_last_q <= o_last_d;
  end

  assign out_o.valid          = o_vld_q;
  assign out_o.hit            = o_hit_q;
  assign out_o.evict_valid    = o_ev_q;
  assign out_o.evicted_block  = o_blk_q;
  assign out_o.resident_count = lte_pkg::CNT_W'(o_cnt_q);
  assign out_o.last           = o_last_q;

endmodule

@@ rtl/lte_tag_ram.sv @@
`timescale 1ns / 1ps
// Tag store ordered by recency: address r holds the block of age rank r.
module lte_tag_ram #(
  parameter int unsigned DEPTH = lte_pkg::CAPACITY,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [lte_pkg::TAG_W-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [lte_pkg::TAG_W-1:0] wr_data_i
);

  logic [lte_pkg::TAG_W-1:0] mem [DEPTH];
  logic [lte_pkg::TAG_W-1:0] rd_data_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/lte_checker.sv @@
`timescale 1ns / 1ps
module lte_checker #(
  parameter int unsigned CAPACITY = lte_pkg::CAPACITY
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      hit,
  input logic                      evict_valid,
  input logic [lte_pkg::TAG_W-1:0] evicted_block,
  input logic [lte_pkg::CNT_W-1:0] resident_count,
  input logic                      last
);

  // A stalled result beat stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // The set never holds more than its capacity.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> 32'(resident_count) <= CAPACITY)
    else $error("resident count above capacity");

  // No evicted block is shown without an eviction.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !evict_valid |-> evicted_block == '0)
    else $error("evicted block without eviction");

  // A hit ends its item and evicts nothing.
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && hit |-> last && !evict_valid)
    else $error("hit beat malformed");

endmodule

bind lru_tracker_threshold_evict lte_checker #(.CAPACITY(CAPACITY)) u_lte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .hit            (out_o.hit),
  .evict_valid    (out_o.evict_valid),
  .evicted_block  (out_o.evicted_block),
  .resident_count (out_o.resident_count),
  .last           (out_o.last)
);
